>>> sv/spq_pkg.sv
package spq_pkg;

   // Number of cells in the chain.
   localparam int CAPACITY = 16;
   // Width of the fill counter, wide enough to hold CAPACITY itself.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int COUNT_OUT_W = 5;

   typedef enum logic [1:0] {
      OP_PEEK   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Command broadcast to every cell in the cycle a beat is accepted.
   typedef struct packed {
      logic               apply;
      op_type             op;
      logic signed [31:0] value;
   } cmd_type;

   // Travels from a cell to its right-hand neighbor (toward the tail).
   typedef struct packed {
      logic signed [31:0] entry;
      logic               valid;
      logic               keep;   // this entry stays put on insert
      logic               hit;    // a remove match lies here or closer to the head
   } tail_link_type;

   // Travels from a cell to its left-hand neighbor (toward the head).
   typedef struct packed {
      logic signed [31:0] entry;
      logic               valid;
   } head_link_type;

endpackage

>>> sv/spq_node.sv
module spq_node (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::cmd_type       cmd,
   input  spq_pkg::tail_link_type from_left,
   input  spq_pkg::head_link_type from_right,
   output spq_pkg::tail_link_type to_right,
   output spq_pkg::head_link_type to_left
);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic               valid_ff;
   logic               valid_in;
   logic               keep;
   logic               hit;

   // Local compares: the queue is sorted, so keep is true for a prefix of the chain.
   assign keep = valid_ff && (entry_ff >= cmd.value);
   assign hit  = from_left.hit || (valid_ff && (entry_ff == cmd.value));

   // Next entry for each operation.
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.apply) begin
         unique case (cmd.op)
            spq_pkg::OP_PEEK: begin
               entry_in = entry_ff;
               valid_in = valid_ff;
            end
            spq_pkg::OP_INSERT: begin
               // Entries past the insertion point move one place toward the tail.
               if (!keep) begin
                  entry_in = from_left.keep ? cmd.value : from_left.entry;
                  valid_in = valid_ff || from_left.valid;
               end
            end
            spq_pkg::OP_POP: begin
               entry_in = from_right.entry;
               valid_in = from_right.valid;
            end
            spq_pkg::OP_REMOVE: begin
               // Entries from the first match onward move one place toward the head.
               if (hit) begin
                  entry_in = from_right.entry;
                  valid_in = from_right.valid;
               end
            end
            default: begin
               entry_in = entry_ff;
               valid_in = valid_ff;
            end
         endcase
      end
   end

   // Entry storage; only the valid bit is reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign to_right.entry = entry_ff;
   assign to_right.valid = valid_ff;
   assign to_right.keep  = keep;
   assign to_right.hit   = hit;
   assign to_left.entry  = entry_ff;
   assign to_left.valid  = valid_ff;

endmodule

>>> sv/sorted_priority_queue.sv
// Channel  Ports      Payload (lowest bit first)
// -------  ---------  ------------------------------------------------------------
// request  req_t*     tuser[1:0] operation; tdata[31:0] value
// response rsp_t*     tuser[1:0] status; tdata result_value, head_after, entry_count
//
// One operation per clock: every cell of the chain compares and shifts in the
// cycle the request beat is accepted, so the rate is set by the compare and
// neighbor shift inside each cell. The response appears in the cycle after
// accept. Reset clears the valid bits of all cells and the fill count. A
// stalled response holds the request side: req_tready falls until it is taken.
module sorted_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic [1:0]  req_tuser,  // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // [31:0] result_value, [63:32] head_after,
                                   // [68:64] entry_count, [71:69] zero
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   spq_pkg::cmd_type       cmd;
   spq_pkg::tail_link_type tail_link [spq_pkg::CAPACITY+1];
   spq_pkg::head_link_type head_link [spq_pkg::CAPACITY+1];

   logic                       accept;
   logic                       full;
   logic                       empty;
   logic signed [31:0]         head_now;
   logic [spq_pkg::CNT_W-1:0]  count_ff;
   logic [spq_pkg::CNT_W-1:0]  count_in;
   logic                       rsp_valid_ff;
   logic signed [31:0]         result_ff;
   logic signed [31:0]         result_in;
   spq_pkg::status_type        status_ff;
   spq_pkg::status_type        status_in;
   logic                       insert_ok;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full     = (count_ff == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
   assign empty    = !head_link[0].valid;
   assign head_now = head_link[0].valid ? head_link[0].entry : 32'sd0;

   assign insert_ok = !full;

   // Command for the chain; a refused insert leaves every cell untouched.
   always_comb begin
      cmd.op    = spq_pkg::op_type'(req_tuser);
      cmd.value = req_tdata;
      cmd.apply = accept &&
                  !((spq_pkg::op_type'(req_tuser) == spq_pkg::OP_INSERT) && !insert_ok);
   end

   // Chain boundaries: the head side always admits the new value, the tail side is empty.
   assign tail_link[0].entry = 32'sd0;
   assign tail_link[0].valid = 1'b1;
   assign tail_link[0].keep  = 1'b1;
   assign tail_link[0].hit   = 1'b0;
   assign head_link[spq_pkg::CAPACITY].entry = 32'sd0;
   assign head_link[spq_pkg::CAPACITY].valid = 1'b0;

   for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_node
      spq_node u_node (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .from_left  (tail_link[i]),
         .from_right (head_link[i+1]),
         .to_right   (tail_link[i+1]),
         .to_left    (head_link[i])
      );
   end

   // Result, status and fill count for the accepted operation.
   always_comb begin
      result_in = head_now;
      status_in = spq_pkg::ST_OK;
      count_in  = count_ff;
      unique case (spq_pkg::op_type'(req_tuser))
         spq_pkg::OP_PEEK: begin
            if (empty) status_in = spq_pkg::ST_EMPTY;
         end
         spq_pkg::OP_INSERT: begin
            if (full) begin
               status_in = spq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + spq_pkg::CNT_W'(1);
            end
         end
         spq_pkg::OP_POP: begin
            if (empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - spq_pkg::CNT_W'(1);
            end
         end
         spq_pkg::OP_REMOVE: begin
            if (tail_link[spq_pkg::CAPACITY].hit) begin
               count_in = count_ff - spq_pkg::CNT_W'(1);
            end else begin
               status_in = spq_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            status_in = spq_pkg::ST_OK;
         end
      endcase
   end

   // Fill count and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         result_ff <= result_in;
         status_ff <= status_in;
      end
   end

   // The chain only moves on accept, which also reloads the response,
   // so the head read straight from the cells and the fill count match this beat.
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata[31:0]   = result_ff;
   assign rsp_tdata[63:32]  = head_now;
   assign rsp_tdata[68:64]  = spq_pkg::COUNT_OUT_W'(count_ff);
   assign rsp_tdata[71:69]  = 3'd0;
   assign rsp_tuser         = status_ff;

endmodule
